/* src/vcsf_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types for the velocity command shaper framer
// no dependencies; imported by the top level, controller and datapath

package vcsf_pkg;

  localparam int FRAME_LEN  = 12;
  localparam int IDX_W      = 4;
  localparam int NUM_AXES   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int LIM_W      = 15;
  localparam int GAIN_W     = 13;
  localparam int SCALE_W    = 39;

  typedef logic [IDX_W-1:0] idx_t;

  // axis lanes
  localparam int AX_X    = 0;
  localparam int AX_Y    = 1;
  localparam int AX_TURN = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TURN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LINEAR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_ANGULAR = 3'd5;

  // register reset values
  localparam logic [LIM_W-1:0]  LIMIT_X_RST       = 15'd6144;
  localparam logic [LIM_W-1:0]  LIMIT_Y_RST       = 15'd0;
  localparam logic [LIM_W-1:0]  LIMIT_TURN_RST    = 15'd4096;
  localparam logic [GAIN_W-1:0] SMOOTH_GAIN_RST   = 13'd819;
  localparam logic [LIM_W-1:0]  FLOOR_LINEAR_RST  = 15'd205;
  localparam logic [LIM_W-1:0]  FLOOR_ANGULAR_RST = 15'd410;

  // function codes
  localparam logic FUNC_SPEED = 1'b0;

  // frame byte positions
  localparam idx_t BYTE_FUNC = 4'd3;
  localparam idx_t BYTE_VX   = 4'd5;
  localparam idx_t BYTE_VY   = 4'd6;
  localparam idx_t BYTE_VR   = 4'd7;
  localparam idx_t BYTE_LAST = 4'(FRAME_LEN - 1);

  localparam logic [7:0] FUNC_SPEED_CODE = 8'h01;

  // unit conversion multipliers
  localparam logic [6:0]  CM_PER_M        = 7'd100;
  localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754936;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } ctl_state_t;

  typedef struct packed {
    logic start;
    idx_t idx;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

endpackage

/* src/vcsf_in_if.sv */
`timescale 1ns / 1ps
// request channel carrying speed commands and odometry requests
// depends on nothing

interface vcsf_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_turn;

  modport source (output valid, func, target_x, target_y, target_turn, input ready);
  modport sink   (input valid, func, target_x, target_y, target_turn, output ready);
endinterface

/* src/vcsf_out_if.sv */
`timescale 1ns / 1ps
// frame byte channel, one byte per handshake, twelve bytes per request
// depends on nothing

interface vcsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, frame_byte, last, input ready);
  modport sink   (input valid, frame_byte, last, output ready);
endinterface

/* src/velocity_command_shaper_framer.sv */
`timescale 1ns / 1ps
// top level of the velocity command shaper and 12-byte serial framer
// depends on vcsf_pkg, vcsf_in_if, vcsf_out_if, vcsf_ctl, vcsf_datapath
//
//   port       dir  carries
//   in_ch      in   one request: func, target_x, target_y, target_turn
//   out_ch     out  frame bytes, last on the twelfth
//   cfg_*      in   register writes, index 0..5, no read-back
//
// one request is the accept handshake on in_ch, then the 12 byte handshakes on out_ch
// the datapath needs five steps after accept; they overlap the five header bytes
// the velocity bytes wait on the datapath, the index only advances on out_ch.ready
// reset is synchronous on rst_n and restores register defaults and zero kept speeds

module velocity_command_shaper_framer #(
  parameter int FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  vcsf_in_if.sink                         in_ch,
  vcsf_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [vcsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vcsf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vcsf_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last),
    .cmd       (cmd),
    .stat      (stat)
  );

  vcsf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (in_ch.func),
    .in_target_x    (in_ch.target_x),
    .in_target_y    (in_ch.target_y),
    .in_target_turn (in_ch.target_turn),
    .cmd            (cmd),
    .stat           (stat),
    .frame_byte     (out_ch.frame_byte)
  );

endmodule

/* src/vcsf_ctl.sv */
`timescale 1ns / 1ps
// controller: accepts requests, steps the frame byte index, runs both handshakes
// depends on vcsf_pkg

module vcsf_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  output vcsf_pkg::dp_cmd_t  cmd,
  input  vcsf_pkg::dp_stat_t stat
);
  import vcsf_pkg::*;

  ctl_state_t state_r, state_nxt;
  idx_t       idx_r, idx_nxt;
  logic       start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        idx_nxt  = '0;
        if (in_valid) begin
          start     = 1'b1;
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        // header bytes go out while the datapath is still working
        out_valid = (idx_r < BYTE_VX) || stat.done;
        out_last  = (idx_r == BYTE_LAST);
        if (out_valid && out_ready) begin
          if (out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cmd.start = start;
  assign cmd.idx   = idx_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("request taken while frame pending");

  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not idle after last byte");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (idx_r == $past(idx_r) + 1'b1))
    else $error("byte index did not advance");

  a_hold_payload_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND && idx_r >= BYTE_VX && !stat.done) |-> !out_valid)
    else $error("velocity byte shown before datapath done");

endmodule

/* src/vcsf_datapath.sv */
`timescale 1ns / 1ps
// datapath: config registers, clamp, smoothing, snap to zero, unit scaling, byte mux
// depends on vcsf_pkg

module vcsf_datapath #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vcsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vcsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_func,
  input  logic signed [15:0]                  in_target_x,
  input  logic signed [15:0]                  in_target_y,
  input  logic signed [15:0]                  in_target_turn,
  input  vcsf_pkg::dp_cmd_t                   cmd,
  output vcsf_pkg::dp_stat_t                  stat,
  output logic [7:0]                          frame_byte
);
  import vcsf_pkg::*;

  localparam int LIN_W  = 24;
  localparam int ANG_SH = FRAC_BITS + 16;

  function automatic logic [7:0] cap_mag(logic [SCALE_W-1:0] q);
    cap_mag = (q > SCALE_W'(128)) ? 8'd128 : q[7:0];
  endfunction

  function automatic logic [7:0] lin_byte(logic [7:0] m, logic neg);
    if (neg) begin
      lin_byte = 8'(8'd0 - m);
    end else begin
      lin_byte = (m > 8'd127) ? 8'd127 : m;
    end
  endfunction

  function automatic logic [7:0] ang_byte(logic [7:0] m, logic neg);
    logic [7:0] rm;
    logic [7:0] h;
    rm = (neg || m <= 8'd127) ? m : 8'd127;
    h  = {1'b0, rm[7:1]};
    ang_byte = neg ? 8'(8'd0 - h) : h;
  endfunction

  function automatic logic [7:0] req_frame_byte(idx_t i);
    unique case (i)
      4'd0:    req_frame_byte = 8'hFE;
      4'd1:    req_frame_byte = 8'hEE;
      4'd2:    req_frame_byte = 8'h05;
      4'd3:    req_frame_byte = 8'h02;
      4'd4:    req_frame_byte = 8'h01;
      4'd5:    req_frame_byte = 8'h01;
      4'd6:    req_frame_byte = 8'h01;
      4'd7:    req_frame_byte = 8'h01;
      4'd8:    req_frame_byte = 8'h55;
      4'd9:    req_frame_byte = 8'hAA;
      4'd10:   req_frame_byte = 8'hFC;
      default: req_frame_byte = 8'hFF;
    endcase
  endfunction

  // config registers
  logic [LIM_W-1:0]  limit_r [NUM_AXES];
  logic [GAIN_W-1:0] gain_r;
  logic [LIM_W-1:0]  floor_lin_r;
  logic [LIM_W-1:0]  floor_ang_r;

  // per-lane state and step registers
  logic signed [15:0] tgt       [NUM_AXES];
  logic signed [15:0] kept_r    [NUM_AXES];
  logic signed [17:0] diff_r    [NUM_AXES];
  logic [LIM_W-1:0]   tmag_r    [NUM_AXES];
  logic signed [31:0] prod_r    [NUM_AXES];
  logic signed [15:0] n_r       [NUM_AXES];
  logic [16:0]        km_r      [NUM_AXES];
  logic               kneg_r    [NUM_AXES];
  logic [LIN_W-1:0]   scl_lin_r [2];
  logic [SCALE_W-1:0] scl_ang_r;
  logic [7:0]         vel_r     [NUM_AXES];

  logic       func_r;
  logic [4:0] stg_r;
  logic       done_r;

  assign tgt[AX_X]    = in_target_x;
  assign tgt[AX_Y]    = in_target_y;
  assign tgt[AX_TURN] = in_target_turn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[AX_X]    <= LIMIT_X_RST;
      limit_r[AX_Y]    <= LIMIT_Y_RST;
      limit_r[AX_TURN] <= LIMIT_TURN_RST;
      gain_r           <= SMOOTH_GAIN_RST;
      floor_lin_r      <= FLOOR_LINEAR_RST;
      floor_ang_r      <= FLOOR_ANGULAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIMIT_X:       limit_r[AX_X]    <= cfg_data[LIM_W-1:0];
        CFG_LIMIT_Y:       limit_r[AX_Y]    <= cfg_data[LIM_W-1:0];
        CFG_LIMIT_TURN:    limit_r[AX_TURN] <= cfg_data[LIM_W-1:0];
        CFG_SMOOTH_GAIN:   gain_r           <= cfg_data[GAIN_W-1:0];
        CFG_FLOOR_LINEAR:  floor_lin_r      <= cfg_data[LIM_W-1:0];
        CFG_FLOOR_ANGULAR: floor_ang_r      <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= '0;
      done_r <= 1'b0;
    end else begin
      stg_r <= {stg_r[3:0], cmd.start};
      if (cmd.start) begin
        done_r <= 1'b0;
      end else if (stg_r[4]) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= in_func;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    logic signed [16:0] tw;
    logic [16:0]        tmag;
    logic               over;
    logic signed [16:0] lim_s;
    logic signed [16:0] tcl;
    logic signed [17:0] diff_c;
    logic signed [31:0] step_c;
    logic signed [32:0] sum_c;
    logic signed [15:0] sat_c;
    logic signed [16:0] nw;
    logic [16:0]        nmag;
    logic [LIM_W-1:0]   fl;
    logic               snap;

    // clamp and difference on the request itself
    always_comb begin
      tw     = {tgt[g][15], tgt[g]};
      tmag   = tw[16] ? 17'(-tw) : 17'(tw);
      lim_s  = {2'b00, limit_r[g]};
      over   = tmag > {2'b00, limit_r[g]};
      tcl    = over ? (tw[16] ? 17'(-lim_s) : lim_s) : tw;
      diff_c = {tcl[16], tcl} - {{2{kept_r[g][15]}}, kept_r[g]};
    end

    // smoothing sum with saturation
    always_comb begin
      step_c = prod_r[g] >>> FRAC_BITS;
      sum_c  = {{17{kept_r[g][15]}}, kept_r[g]} + {step_c[31], step_c};
      if (sum_c > 33'sd32767) begin
        sat_c = 16'sh7FFF;
      end else if (sum_c < -33'sd32768) begin
        sat_c = 16'sh8000;
      end else begin
        sat_c = sum_c[15:0];
      end
    end

    // snap to zero while slow and decelerating
    always_comb begin
      nw   = {n_r[g][15], n_r[g]};
      nmag = nw[16] ? 17'(-nw) : 17'(nw);
      fl   = (g == AX_TURN) ? floor_ang_r : floor_lin_r;
      snap = (nmag < {2'b00, fl}) && ({2'b00, tmag_r[g]} < nmag);
    end

    always_ff @(posedge clk) begin
      if (cmd.start) begin
        diff_r[g] <= diff_c;
        tmag_r[g] <= over ? limit_r[g] : tmag[LIM_W-1:0];
      end
      if (stg_r[0]) begin
        prod_r[g] <= $signed({1'b0, gain_r}) * diff_r[g];
      end
      if (stg_r[1]) begin
        n_r[g] <= sat_c;
      end
      if (stg_r[2]) begin
        km_r[g]   <= snap ? 17'd0 : nmag;
        kneg_r[g] <= !snap && n_r[g][15];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kept_r[g] <= '0;
      end else if (stg_r[2] && func_r == FUNC_SPEED) begin
        kept_r[g] <= snap ? 16'sd0 : n_r[g];
      end
    end
  end

  // unit scaling, then truncation and byte saturation
  always_ff @(posedge clk) begin
    if (stg_r[3]) begin
      scl_lin_r[AX_X] <= LIN_W'(km_r[AX_X]) * LIN_W'(CM_PER_M);
      scl_lin_r[AX_Y] <= LIN_W'(km_r[AX_Y]) * LIN_W'(CM_PER_M);
      scl_ang_r       <= SCALE_W'(km_r[AX_TURN]) * SCALE_W'(DEG_PER_RAD_Q16);
    end
    if (stg_r[4]) begin
      vel_r[AX_X]    <= lin_byte(cap_mag(SCALE_W'(scl_lin_r[AX_X] >> FRAC_BITS)),
                                 kneg_r[AX_X]);
      vel_r[AX_Y]    <= lin_byte(cap_mag(SCALE_W'(scl_lin_r[AX_Y] >> FRAC_BITS)),
                                 kneg_r[AX_Y]);
      vel_r[AX_TURN] <= ang_byte(cap_mag(scl_ang_r >> ANG_SH), kneg_r[AX_TURN]);
    end
  end

  always_comb begin
    frame_byte = req_frame_byte(cmd.idx);
    if (func_r == FUNC_SPEED) begin
      unique case (cmd.idx)
        BYTE_FUNC: frame_byte = FUNC_SPEED_CODE;
        BYTE_VX:   frame_byte = vel_r[AX_X];
        BYTE_VY:   frame_byte = vel_r[AX_Y];
        BYTE_VR:   frame_byte = vel_r[AX_TURN];
        default: begin
        end
      endcase
    end
  end

  assign stat.done = done_r;

endmodule
